// ===== hw/rtl/dtid_pkg.sv =====
// Shared types, constants and latencies of the disparity to inverse depth pipeline.
`default_nettype none
package dtid_pkg;

  localparam int COL_W      = 12;
  localparam int DISP_W     = 21;
  localparam int MAP_W      = 13;
  localparam int BASE_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int INV_W      = 32;

  localparam int XQ_W      = 22;
  localparam int ABS_W     = 21;
  localparam int RED_STEPS = 12;
  localparam int TH_W      = 31;
  localparam int X2_W      = 32;
  localparam int SIN_W     = 31;
  localparam int DEN_W     = 51;

  localparam logic [31:0]      PI_Q30  = 32'd3373259426;
  localparam logic [TH_W-1:0]  ONE_Q30 = 31'h4000_0000;
  localparam logic [INV_W-1:0] INV_MIN = 32'd262;
  localparam logic [INV_W-1:0] INV_MAX = 32'd2621440000;

  localparam int HORNER_N     = 5;
  localparam int HORNER_SHIFT = 35;
  localparam logic [6:0]  HORNER_K [HORNER_N] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [32:0] HORNER_M [HORNER_N] = '{
    33'd312361257, 33'd477218588, 33'd818089008, 33'd1717986918, 33'd5726623061
  };

  localparam int RED_LAT  = 1 + RED_STEPS + 2 + 1 + TH_W;
  localparam int SIN_LAT  = 1 + 3 * HORNER_N + 1;
  localparam int QUO_LAT  = 2 + INV_W + 1;
  localparam int PIPE_LAT = RED_LAT + SIN_LAT + QUO_LAT;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MIN  = 2'd1,
    CLAMP_MAX  = 2'd2
  } clamp_e;

  typedef enum logic {
    REG_MAP_SIZE = 1'b0,
    REG_BASELINE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TH_W-1:0] th;
    logic            neg;
    logic            zero;
  } angle_t;

  typedef struct packed {
    logic [SIN_W-1:0] mag;
    logic             neg;
    logic             zero;
  } sine_t;

endpackage
`default_nettype wire

// ===== hw/rtl/disparity_to_inverse_depth_top.sv =====
// Top level of the disparity to inverse depth pipeline with its configuration registers.
//
//   Channel | Direction | Handshake              | Payload
//   in      | request   | in_valid_i, in_stall_o | column_i, disparity_i
//   out     | result    | out_valid_o, out_stall_i | inverse_depth_o, clamp_state_o
//   cfg     | write     | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request enters per cycle while the output is not stalled.
// Most of the pipeline depth lies in the two bit-per-stage dividers: angle scaling and the final ratio.
// Reset clears the valid bits and loads map size 2048 and baseline 4194.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none
module disparity_to_inverse_depth_top #(
  parameter int MAX_MAP_SIZE = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dtid_pkg::COL_W-1:0]      column_i,
  input  logic signed [dtid_pkg::DISP_W-1:0] disparity_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dtid_pkg::INV_W-1:0]      inverse_depth_o,
  output dtid_pkg::clamp_e                clamp_state_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  dtid_pkg::cfg_reg_e              cfg_index_i,
  input  logic [dtid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dtid_pkg::*;

  localparam int NW = $clog2(MAX_MAP_SIZE + 1);

  logic [MAP_W-1:0]  map_size_q;
  logic [BASE_W-1:0] baseline_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= 13'd2048;
      baseline_q <= 20'd4194;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAP_SIZE: map_size_q <= cfg_data_i[MAP_W-1:0];
        REG_BASELINE: baseline_q <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0]     n_eff;
  logic [BASE_W-1:0] b_eff;

  always_comb begin
    if (map_size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(map_size_q) > 32'(MAX_MAP_SIZE)) begin
      n_eff = NW'(MAX_MAP_SIZE);
    end else begin
      n_eff = NW'(map_size_q);
    end
    if (baseline_q == '0) begin
      b_eff = BASE_W'(1);
    end else begin
      b_eff = baseline_q;
    end
  end

  logic                en;
  logic [PIPE_LAT-1:0] valid_q;

  assign en         = !valid_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o = !en || !rst_ni;
  assign out_valid_o = valid_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  logic [XQ_W-1:0] xq_num, xq_den;
  assign xq_num = {disparity_i[DISP_W-1], disparity_i};
  assign xq_den = {2'b00, column_i, 8'h00} + {disparity_i[DISP_W-1], disparity_i};

  angle_t ang_num, ang_den;
  sine_t  sin_num, sin_den;

  dtid_reduce #(.NW(NW)) u_reduce_num (
    .clk_i   (clk_i),
    .en_i    (en),
    .n_i     (n_eff),
    .xq_i    (xq_num),
    .angle_o (ang_num)
  );

  dtid_reduce #(.NW(NW)) u_reduce_den (
    .clk_i   (clk_i),
    .en_i    (en),
    .n_i     (n_eff),
    .xq_i    (xq_den),
    .angle_o (ang_den)
  );

  dtid_sine u_sine_num (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_num),
    .sine_o  (sin_num)
  );

  dtid_sine u_sine_den (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_den),
    .sine_o  (sin_den)
  );

  dtid_quot u_quot (
    .clk_i   (clk_i),
    .en_i    (en),
    .base_i  (b_eff),
    .num_i   (sin_num),
    .den_i   (sin_den),
    .inv_o   (inverse_depth_o),
    .state_o (clamp_state_o)
  );

  a_min_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamp_state_o == CLAMP_MIN |-> inverse_depth_o == INV_MIN)
    else $error("Low clamp without the minimum value.");

  a_max_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamp_state_o == CLAMP_MAX |-> inverse_depth_o == INV_MAX)
    else $error("High clamp without the maximum value.");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamp_state_o == CLAMP_NONE
      |-> inverse_depth_o >= INV_MIN && inverse_depth_o <= INV_MAX)
    else $error("Unclamped result outside the allowed range.");

endmodule
`default_nettype wire

// ===== hw/rtl/dtid_reduce.sv =====
// Period reduction, quarter-wave fold and angle scaling of one sine argument.
`default_nettype none
module dtid_reduce #(
  parameter int NW = 13
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [NW-1:0]             n_i,
  input  logic [dtid_pkg::XQ_W-1:0] xq_i,
  output dtid_pkg::angle_t          angle_o
);
  import dtid_pkg::*;

  localparam int PW = NW + 9;
  localparam int SW = PW + RED_STEPS - 1;
  localparam int RW = NW + 7;
  localparam int MW = RW + 32;
  localparam int DW = NW + 31;

  logic [PW-1:0] period, half, quarter;
  assign period  = {n_i, 9'd0};
  assign half    = PW'({n_i, 8'd0});
  assign quarter = PW'({n_i, 7'd0});

  logic [ABS_W-1:0] rem_q [RED_STEPS+1];
  logic             sgn_q [RED_STEPS+1];
  logic [ABS_W-1:0] abs_d;

  always_comb begin
    if (xq_i[XQ_W-1]) begin
      abs_d = ABS_W'(-xq_i);
    end else begin
      abs_d = ABS_W'(xq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= abs_d;
      sgn_q[0] <= xq_i[XQ_W-1];
    end
  end

  for (genvar g = 0; g < RED_STEPS; g++) begin : g_mod
    logic [SW-1:0]    cmp;
    logic [ABS_W-1:0] nxt;
    always_comb begin
      cmp = SW'(period) << (RED_STEPS - 1 - g);
      if (SW'(rem_q[g]) >= cmp) begin
        nxt = rem_q[g] - ABS_W'(cmp);
      end else begin
        nxt = rem_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1] <= nxt;
        sgn_q[g+1] <= sgn_q[g];
      end
    end
  end

  // Negative arguments wrap back into the period, then the second half folds onto the first.
  logic [PW-1:0] m0, f1_d, f1_q;
  logic          neg1_d, neg1_q;

  always_comb begin
    m0 = PW'(rem_q[RED_STEPS]);
    if (sgn_q[RED_STEPS] && m0 != '0) begin
      m0 = period - m0;
    end
    if (m0 >= half) begin
      f1_d   = m0 - half;
      neg1_d = 1'b1;
    end else begin
      f1_d   = m0;
      neg1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= f1_d;
      neg1_q <= neg1_d;
    end
  end

  logic [PW-1:0] f2_d;
  logic [RW-1:0] r_q;
  logic          neg2_q, zero2_q;

  always_comb begin
    if (f1_q > quarter) begin
      f2_d = half - f1_q;
    end else begin
      f2_d = f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q     <= RW'(f2_d);
      neg2_q  <= neg1_q;
      zero2_q <= (f2_d == '0);
    end
  end

  logic [MW-1:0] prod;
  assign prod = MW'(r_q) * MW'(PI_Q30);

  logic [DW-1:0]   dr_q   [TH_W+1];
  logic [TH_W-1:0] qt_q   [TH_W+1];
  logic            dneg_q [TH_W+1];
  logic            dzero_q[TH_W+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q[0]    <= DW'(prod >> 8);
      qt_q[0]    <= '0;
      dneg_q[0]  <= neg2_q;
      dzero_q[0] <= zero2_q;
    end
  end

  for (genvar j = 0; j < TH_W; j++) begin : g_div
    logic [DW-1:0] cmp;
    logic [DW-1:0] nxt;
    logic          bit_d;
    always_comb begin
      cmp = DW'(n_i) << (TH_W - 1 - j);
      if (dr_q[j] >= cmp) begin
        nxt   = dr_q[j] - cmp;
        bit_d = 1'b1;
      end else begin
        nxt   = dr_q[j];
        bit_d = 1'b0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j+1]    <= nxt;
        qt_q[j+1]    <= {qt_q[j][TH_W-2:0], bit_d};
        dneg_q[j+1]  <= dneg_q[j];
        dzero_q[j+1] <= dzero_q[j];
      end
    end
  end

  assign angle_o.th   = qt_q[TH_W];
  assign angle_o.neg  = dneg_q[TH_W];
  assign angle_o.zero = dzero_q[TH_W];

endmodule
`default_nettype wire

// ===== hw/rtl/dtid_sine.sv =====
// Pipelined Horner evaluation of the sine series on a reduced angle.
`default_nettype none
module dtid_sine (
  input  logic             clk_i,
  input  logic             en_i,
  input  dtid_pkg::angle_t angle_i,
  output dtid_pkg::sine_t  sine_o
);
  import dtid_pkg::*;

  localparam int Q0_W = 30;
  localparam int PA_W = X2_W + TH_W;
  localparam int PB_W = X2_W + 33;

  typedef struct packed {
    logic [TH_W-1:0] th;
    logic [X2_W-1:0] x2;
    logic            neg;
    logic            zero;
  } side_t;

  side_t           sc_q [HORNER_N+1];
  logic [TH_W-1:0] t_q  [HORNER_N+1];
  side_t           sa_q [HORNER_N];
  side_t           sb_q [HORNER_N];
  logic [X2_W-1:0] va_q [HORNER_N];
  logic [X2_W-1:0] vb_q [HORNER_N];
  logic [Q0_W-1:0] q0_q [HORNER_N];

  logic [2*TH_W-1:0] sq;
  assign sq = (2*TH_W)'(angle_i.th) * (2*TH_W)'(angle_i.th);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q[0].th   <= angle_i.th;
      sc_q[0].x2   <= X2_W'(sq >> 30);
      sc_q[0].neg  <= angle_i.neg;
      sc_q[0].zero <= angle_i.zero;
      t_q[0]       <= ONE_Q30;
    end
  end

  for (genvar i = 0; i < HORNER_N; i++) begin : g_horner
    logic [PA_W-1:0] pa;
    logic [PB_W-1:0] pb;
    logic [X2_W-1:0] pk, diff;
    logic [Q0_W-1:0] qq;

    assign pa = PA_W'(sc_q[i].x2) * PA_W'(t_q[i]);
    assign pb = PB_W'(va_q[i]) * PB_W'(HORNER_M[i]);

    // The reciprocal product is at most one below the true quotient.
    always_comb begin
      pk   = X2_W'(q0_q[i]) * X2_W'(HORNER_K[i]);
      diff = vb_q[i] - pk;
      if (diff >= X2_W'(HORNER_K[i])) begin
        qq = q0_q[i] + Q0_W'(1);
      end else begin
        qq = q0_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        va_q[i]   <= X2_W'(pa >> 30);
        sa_q[i]   <= sc_q[i];
        vb_q[i]   <= va_q[i];
        q0_q[i]   <= Q0_W'(pb >> HORNER_SHIFT);
        sb_q[i]   <= sa_q[i];
        t_q[i+1]  <= ONE_Q30 - TH_W'(qq);
        sc_q[i+1] <= sb_q[i];
      end
    end
  end

  logic [2*TH_W-1:0] fin;
  assign fin = (2*TH_W)'(sc_q[HORNER_N].th) * (2*TH_W)'(t_q[HORNER_N]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_o.mag  <= SIN_W'(fin >> 30);
      sine_o.neg  <= sc_q[HORNER_N].neg;
      sine_o.zero <= sc_q[HORNER_N].zero;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dtid_quot.sv =====
// Ratio of the two sines over the baseline by long division, with clamping.
`default_nettype none
module dtid_quot (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dtid_pkg::BASE_W-1:0] base_i,
  input  dtid_pkg::sine_t             num_i,
  input  dtid_pkg::sine_t             den_i,
  output logic [dtid_pkg::INV_W-1:0]  inv_o,
  output dtid_pkg::clamp_e            state_o
);
  import dtid_pkg::*;

  localparam int RRW = DEN_W + 1;

  logic [DEN_W-1:0] den0_q;
  logic [SIN_W-1:0] an0_q;
  clamp_e           cls0_q, cls0_d;

  always_comb begin
    if (num_i.zero) begin
      cls0_d = CLAMP_MIN;
    end else if (den_i.zero) begin
      cls0_d = CLAMP_MAX;
    end else if (num_i.neg != den_i.neg) begin
      cls0_d = CLAMP_MIN;
    end else begin
      cls0_d = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den0_q <= DEN_W'(base_i) * DEN_W'(den_i.mag);
      an0_q  <= num_i.mag;
      cls0_q <= cls0_d;
    end
  end

  logic [RRW-1:0]   rr_q  [INV_W+1];
  logic [DEN_W-1:0] dn_q  [INV_W+1];
  logic [INV_W-1:0] qt_q  [INV_W+1];
  clamp_e           cls_q [INV_W+1];
  logic             ovf_q [INV_W+1];
  logic [RRW-1:0]   r0;

  assign r0 = RRW'({an0_q, 2'b00});

  // A quotient of 2^32 or more is known at once and saturates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q[0]  <= r0;
      dn_q[0]  <= den0_q;
      qt_q[0]  <= '0;
      cls_q[0] <= cls0_q;
      ovf_q[0] <= (r0 >= RRW'(den0_q));
    end
  end

  for (genvar j = 0; j < INV_W; j++) begin : g_div
    logic [RRW-1:0] sh, nxt;
    logic           bit_d;
    always_comb begin
      sh = rr_q[j] << 1;
      if (sh >= RRW'(dn_q[j])) begin
        nxt   = sh - RRW'(dn_q[j]);
        bit_d = 1'b1;
      end else begin
        nxt   = sh;
        bit_d = 1'b0;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rr_q[j+1]  <= nxt;
        dn_q[j+1]  <= dn_q[j];
        qt_q[j+1]  <= {qt_q[j][INV_W-2:0], bit_d};
        cls_q[j+1] <= cls_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  logic [INV_W-1:0] q;
  logic [INV_W-1:0] inv_d;
  clamp_e           state_d;

  assign q = qt_q[INV_W];

  always_comb begin
    case (cls_q[INV_W])
      CLAMP_MIN: begin
        inv_d   = INV_MIN;
        state_d = CLAMP_MIN;
      end
      CLAMP_MAX: begin
        inv_d   = INV_MAX;
        state_d = CLAMP_MAX;
      end
      default: begin
        if (ovf_q[INV_W] || q > INV_MAX) begin
          inv_d   = INV_MAX;
          state_d = CLAMP_MAX;
        end else if (q < INV_MIN) begin
          inv_d   = INV_MIN;
          state_d = CLAMP_MIN;
        end else begin
          inv_d   = q;
          state_d = CLAMP_NONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_o   <= inv_d;
      state_o <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_disparity_to_inverse_depth_top.sv =====
// Self-checking testbench of the disparity to inverse depth pipeline.
`timescale 1ns / 1ps
module tb_disparity_to_inverse_depth_top;
  import dtid_pkg::*;

  localparam int LATENCY = 99;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [INV_W-1:0] inv;
    clamp_e           clamp;
  } depth_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [COL_W-1:0] column_i = '0;
  logic signed [DISP_W-1:0] disparity_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [INV_W-1:0] inverse_depth_o;
  clamp_e clamp_state_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_reg_e cfg_index_i = REG_MAP_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [MAP_W-1:0] cur_map_size = 13'd2048;
  logic [BASE_W-1:0] cur_baseline = 20'd4194;
  depth_t expected_depths[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int rx_wait = 0;

  disparity_to_inverse_depth_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint sine_q30(longint xq, longint n);
    longint period, half, quarter, r;
    logic [63:0] th, x2, t, s;
    longint k[5];
    bit neg;
    k = '{110, 72, 42, 20, 6};
    period = 512 * n;
    half = 256 * n;
    quarter = 128 * n;
    neg = 1'b0;
    r = xq % period;
    if (r < 0) r += period;
    if (r >= half) begin
      r -= half;
      neg = 1'b1;
    end
    if (r > quarter) r = half - r;
    if (r == 0) return 0;
    th = (64'(r) * 64'd3373259426) / 64'(half);
    x2 = (th * th) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(k[i]);
    s = (th * t) >> 30;
    return neg ? -longint'(s) : longint'(s);
  endfunction

  function automatic depth_t inverse_depth_of(logic [COL_W-1:0] col, logic signed [DISP_W-1:0] d);
    longint n, sn, sd;
    logic [63:0] b, num, den, qhi, rem, q;
    depth_t r;
    n = cur_map_size == 0 ? 1 : (cur_map_size > 4096 ? 4096 : longint'(cur_map_size));
    b = cur_baseline == 0 ? 64'd1 : 64'(cur_baseline);
    sn = sine_q30(longint'(d), n);
    sd = sine_q30(longint'(col) * 256 + longint'(d), n);
    if (sn == 0) r = '{INV_MIN, CLAMP_MIN};
    else if (sd == 0) r = '{INV_MAX, CLAMP_MAX};
    else if ((sn < 0) != (sd < 0)) r = '{INV_MIN, CLAMP_MIN};
    else begin
      num = 64'(sn < 0 ? -sn : sn) << 30;
      den = b * 64'(sd < 0 ? -sd : sd);
      qhi = num / den;
      rem = num % den;
      if (qhi > 64'd2621440000 / 16 + 1) q = 64'd2621440001;
      else q = qhi * 16 + (rem * 16) / den;
      if (q < 262) r = '{INV_MIN, CLAMP_MIN};
      else if (q > 64'd2621440000) r = '{INV_MAX, CLAMP_MAX};
      else r = '{q[31:0], CLAMP_NONE};
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_depths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %0d", inverse_depth_o);
      end else begin
        depth_t e;
        e = expected_depths.pop_front();
        if (e.inv !== inverse_depth_o || e.clamp !== clamp_state_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0d, got %0d/%0d", e.inv, e.clamp,
                     inverse_depth_o, clamp_state_o);
        end
      end
    end
  end

  bit random_stall = 1'b0;
  always @(posedge clk_i) begin
    int w;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      w = random_stall ? $urandom_range(0, 10) : 0;
      rx_wait <= w;
      out_stall_i <= (w > 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall_i <= (rx_wait > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  bit sender_gaps = 1'b0;

  task automatic send_request(logic [COL_W-1:0] col, logic signed [DISP_W-1:0] d);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    column_i <= col;
    disparity_i <= d;
    in_valid_i <= 1'b1;
    expected_depths = {expected_depths, inverse_depth_of(col, d)};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_depths.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MAP_SIZE) cur_map_size = value[MAP_W-1:0];
    else cur_baseline = value[BASE_W-1:0];
  endtask

  task automatic random_requests(int count);
    logic [COL_W-1:0] col;
    logic signed [DISP_W-1:0] d;
    repeat (count) begin
      col = COL_W'($urandom);
      case ($urandom_range(0, 3))
        0: d = DISP_W'($urandom);
        1: d = DISP_W'($signed($urandom_range(0, 64 * 256)) - 8 * 256);
        2: d = DISP_W'(int'($urandom_range(0, 256)) * 256);
        default: d = DISP_W'($urandom_range(0, 4096));
      endcase
      send_request(col, d);
    end
  endtask

  task automatic test_directed();
    send_request(12'd0, 21'sd0);
    send_request(12'hFFF, 21'h0FFFFF);
    send_request(12'hFFF, 21'h100000);
    send_request(12'd0, 21'sd256);
    send_request(12'd100, 21'sd256);
    send_request(12'd2047, 21'sd256);
    send_request(12'd2048, 21'sd0);
    send_request(12'd1024, 21'sd512);
    send_request(12'd10, -21'sd256);
    send_request(12'd1, 21'sd1);
    send_request(12'd4000, 21'sd300000);
    send_request(12'd5, 21'h1FFFFF);
    send_request(12'd1000, 21'sd268288);
  endtask

  task automatic test_extreme_config();
    write_register(REG_MAP_SIZE, 20'd1);
    write_register(REG_BASELINE, 20'hFFFFF);
    send_request(12'd0, 21'sd64);
    send_request(12'd3, 21'sd100);
    random_requests(40);
    write_register(REG_MAP_SIZE, 20'd0);
    write_register(REG_BASELINE, 20'd0);
    send_request(12'd0, 21'sd64);
    random_requests(40);
    write_register(REG_MAP_SIZE, 20'h1FFF);
    write_register(REG_BASELINE, 20'd1);
    random_requests(60);
    write_register(REG_MAP_SIZE, 20'd4096);
    random_requests(60);
  endtask

  task automatic test_random_traffic();
    sender_gaps = 1'b1;
    random_stall = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      write_register(REG_MAP_SIZE, CFG_DATA_W'($urandom_range(16, 4096)));
      write_register(REG_BASELINE, CFG_DATA_W'($urandom_range(1, 1048575)));
      random_requests(250);
    end
    write_register(REG_MAP_SIZE, 20'd2048);
    write_register(REG_BASELINE, 20'd4194);
    random_stall = 1'b0;
    sender_gaps = 1'b0;
    random_requests(100);
  endtask

  task automatic test_backpressure();
    hold_req++;
    random_requests(200);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_config();
    test_random_traffic();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_depths.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== disparity_to_inverse_depth_top.f =====
hw/rtl/dtid_pkg.sv
hw/rtl/dtid_reduce.sv
hw/rtl/dtid_sine.sv
hw/rtl/dtid_quot.sv
hw/rtl/disparity_to_inverse_depth_top.sv
dv/tb_disparity_to_inverse_depth_top.sv
